// File: hdl/farey_pkg.sv
// shared types and constants for the farey mediant approximator
`default_nettype none

package farey_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LIMIT_W       = 16;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd10000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MUL,
        S_ADD,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic mul;
        logic fin;
    } cmd_t;

    typedef struct packed {
        logic match;
    } status_t;

endpackage

`default_nettype wire

// File: hdl/farey_mediant_rational_approx.sv
// top level: farey mediant rational approximation of a fixed-point value
// done follows the start transfer through the search steps and the MUL, ADD and OUT states;
//   the search ends when a match is found or the step count reaches iteration_limit
// a new value is accepted only in idle; busy stays high from start to done
// the done strobe lasts one cycle and the receiver cannot stall it
// asynchronous active-low reset returns to idle with iteration_limit = 10000
`default_nettype none

module farey_mediant_rational_approx #(
    parameter int FRAC_BITS = farey_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [31:0]            value,
    output logic                               done,
    output logic signed [31:0]                 numerator,
    output logic [16:0]                        denominator,
    output logic                               exact,
    output logic                               saturated,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [farey_pkg::LIMIT_W-1:0] cfg_data
);

    farey_pkg::cmd_t    cmd;
    farey_pkg::status_t status;

    farey_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    farey_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .value       (value),
        .numerator   (numerator),
        .denominator (denominator),
        .exact       (exact),
        .saturated   (saturated)
    );

endmodule

`default_nettype wire

// File: hdl/farey_dp.sv
// datapath: mediant bounds, running cross-product errors and final scaling
`default_nettype none

module farey_dp #(
    parameter int FRAC_BITS = farey_pkg::FRAC_BITS_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire farey_pkg::cmd_t      cmd,
    output farey_pkg::status_t        status,
    input  wire logic signed [31:0]   value,
    output logic signed [31:0]        numerator,
    output logic [16:0]               denominator,
    output logic                      exact,
    output logic                      saturated
);

    localparam int DW  = FRAC_BITS + 1;
    localparam int EW  = 2 * FRAC_BITS + 2;
    localparam int FLW = 32 - FRAC_BITS;
    localparam int PW  = 34;
    localparam logic signed [PW-1:0] NUM_MAX = PW'(2147483647);
    localparam logic signed [PW-1:0] NUM_MIN = -NUM_MAX - PW'(1);

    logic signed [FLW-1:0]  fl_reg;
    logic [DW-1:0]          hn_reg, hn_next;
    logic [DW-1:0]          hd_reg, hd_next;
    logic [DW-1:0]          ln_reg, ln_next;
    logic [DW-1:0]          ld_reg, ld_next;
    logic signed [EW-1:0]   eh_reg, eh_next;
    logic signed [EW-1:0]   el_reg, el_next;
    logic                   found_reg, found_next;
    logic signed [PW-1:0]   prod_reg;
    logic signed [PW-1:0]   sum;
    logic signed [31:0]     num_reg;
    logic [16:0]            den_reg;
    logic                   sat_reg;

    logic signed [EW-1:0]   em;
    logic [DW-1:0]          mn;
    logic [DW-1:0]          md;
    logic                   low_hit;
    logic                   med_hit;

    assign em      = eh_reg + el_reg;
    assign mn      = hn_reg + ln_reg;
    assign md      = hd_reg + ld_reg;
    assign low_hit = (el_reg == '0);
    assign med_hit = (em == '0);
    assign status.match = low_hit || med_hit;

    always_comb
    begin
        hn_next    = hn_reg;
        hd_next    = hd_reg;
        ln_next    = ln_reg;
        ld_next    = ld_reg;
        eh_next    = eh_reg;
        el_next    = el_reg;
        found_next = found_reg;
        if (cmd.load)
        begin
            hn_next    = DW'(1);
            hd_next    = DW'(1);
            ln_next    = '0;
            ld_next    = DW'(1);
            eh_next    = $signed(EW'(1) << FRAC_BITS) - $signed(EW'(value[FRAC_BITS-1:0]));
            el_next    = -$signed(EW'(value[FRAC_BITS-1:0]));
            found_next = 1'b0;
        end
        else if (cmd.step)
        begin
            if (low_hit)
            begin
                hn_next    = ln_reg;
                hd_next    = ld_reg;
                found_next = 1'b1;
            end
            else if (med_hit)
            begin
                hn_next    = mn;
                hd_next    = md;
                ln_next    = mn;
                ld_next    = md;
                eh_next    = em;
                el_next    = em;
                found_next = 1'b1;
            end
            else if (em < 0)
            begin
                ln_next = mn;
                ld_next = md;
                el_next = em;
            end
            else
            begin
                hn_next = mn;
                hd_next = md;
                eh_next = em;
            end
        end
    end

    assign sum = $signed(PW'(hn_reg)) + prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hn_reg <= hn_next;
        hd_reg <= hd_next;
        ln_reg <= ln_next;
        ld_reg <= ld_next;
        eh_reg <= eh_next;
        el_reg <= el_next;
        if (cmd.load)
        begin
            fl_reg <= value[31:FRAC_BITS];
        end
        if (cmd.mul)
        begin
            prod_reg <= PW'(fl_reg) * $signed(PW'(hd_reg));
        end
        if (cmd.fin)
        begin
            den_reg <= 17'(hd_reg);
            if (sum > NUM_MAX)
            begin
                num_reg <= 32'(NUM_MAX);
                sat_reg <= 1'b1;
            end
            else if (sum < NUM_MIN)
            begin
                num_reg <= 32'(NUM_MIN);
                sat_reg <= 1'b1;
            end
            else
            begin
                num_reg <= 32'(sum);
                sat_reg <= 1'b0;
            end
        end
    end

    assign numerator   = num_reg;
    assign denominator = den_reg;
    assign exact       = found_reg;
    assign saturated   = sat_reg;

`ifndef SYNTHESIS
    a_match_sets_found: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && status.match) |=> found_reg)
        else $error("exact match did not set found flag");
    a_load_clears_found: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !found_reg)
        else $error("found flag not cleared on load");
    a_low_err_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.load) |-> (el_reg <= 0) && (eh_reg > 0))
        else $error("initial bound errors have wrong sign");
`endif

endmodule

`default_nettype wire

// File: hdl/farey_ctrl.sv
// controller: sequencing fsm, step counter and iteration limit register
`default_nettype none

module farey_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    output logic                               done,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [farey_pkg::LIMIT_W-1:0] cfg_data,
    output farey_pkg::cmd_t                    cmd,
    input  wire farey_pkg::status_t            status
);

    farey_pkg::state_t               state_reg, state_next;
    logic [farey_pkg::LIMIT_W-1:0]   limit_reg;
    logic [farey_pkg::LIMIT_W-1:0]   cnt_reg, cnt_next;
    logic                            at_limit;

    assign at_limit  = (cnt_reg == limit_reg);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            farey_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = farey_pkg::S_STEP;
                end
            end
            farey_pkg::S_STEP:
            begin
                if (at_limit || status.match)
                begin
                    state_next = farey_pkg::S_MUL;
                end
            end
            farey_pkg::S_MUL:
            begin
                state_next = farey_pkg::S_ADD;
            end
            farey_pkg::S_ADD:
            begin
                state_next = farey_pkg::S_OUT;
            end
            farey_pkg::S_OUT:
            begin
                state_next = farey_pkg::S_IDLE;
            end
            default:
            begin
                state_next = farey_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        busy     = 1'b1;
        done     = 1'b0;
        cnt_next = cnt_reg;
        unique case (state_reg)
            farey_pkg::S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
                cnt_next = '0;
            end
            farey_pkg::S_STEP:
            begin
                cmd.step = !at_limit;
                if (!at_limit)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            farey_pkg::S_MUL:
            begin
                cmd.mul = 1'b1;
            end
            farey_pkg::S_ADD:
            begin
                cmd.fin = 1'b1;
            end
            farey_pkg::S_OUT:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= farey_pkg::S_IDLE;
            cnt_reg   <= '0;
            limit_reg <= farey_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_enters_step: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == farey_pkg::S_STEP) && (cnt_reg == '0))
        else $error("accepted transfer did not start search");
    a_done_after_add: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == farey_pkg::S_ADD))
        else $error("result strobe without final add");
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

// File: test/tb.sv
// testbench for the farey mediant rational approximator: predicted results vs dut outputs
`default_nettype none

module tb;

    localparam int FRAC = farey_pkg::FRAC_BITS_DEF;
    localparam longint unsigned FRAC_MASK = (64'd1 << FRAC) - 64'd1;
    localparam longint NUM_MAX = 64'sd2147483647;
    localparam longint NUM_MIN = -64'sd2147483648;
    localparam int STALL_LIMIT = 300000;
    localparam int PHASES = 5;
    localparam int PHASE_ITEMS = 20;

    typedef struct packed {
        logic [31:0]        source;
        logic signed [31:0] numerator;
        logic [16:0]        denominator;
        logic               exact;
        logic               saturated;
    } approx_t;

    class approx_scoreboard;
        approx_t expected_q[$];
        int errors;

        function new();
            errors = 0;
        endfunction

        function int mediant_cmp(longint unsigned n, longint unsigned d, longint unsigned f);
            longint unsigned lhs;
            longint unsigned rhs;
            lhs = n << FRAC;
            rhs = f * d;
            if (lhs < rhs)
                return -1;
            if (lhs > rhs)
                return 1;
            return 0;
        endfunction

        function approx_t predict_approx(logic [31:0] raw, int unsigned lim);
            longint unsigned f;
            longint unsigned hn;
            longint unsigned hd;
            longint unsigned ln;
            longint unsigned ld;
            longint unsigned mn;
            longint unsigned md;
            longint fl;
            longint r;
            bit found;
            bit sat;
            int c;
            approx_t res;
            f = raw & FRAC_MASK;
            fl = $signed(raw);
            fl = fl >>> FRAC;
            hn = 1;
            hd = 1;
            ln = 0;
            ld = 1;
            found = 0;
            sat = 0;
            for (int unsigned i = 0; i < lim; i++)
            begin
                if (mediant_cmp(hn, hd, f) == 0)
                begin
                    ln = hn;
                    ld = hd;
                    found = 1;
                    break;
                end
                if (mediant_cmp(ln, ld, f) == 0)
                begin
                    hn = ln;
                    hd = ld;
                    found = 1;
                    break;
                end
                mn = hn + ln;
                md = hd + ld;
                c = mediant_cmp(mn, md, f);
                if (c == 0)
                begin
                    hn = mn;
                    hd = md;
                    found = 1;
                    break;
                end
                else if (c < 0)
                begin
                    ln = mn;
                    ld = md;
                end
                else
                begin
                    hn = mn;
                    hd = md;
                end
            end
            r = $signed(hn) + fl * $signed(hd);
            if (r > NUM_MAX)
            begin
                r = NUM_MAX;
                sat = 1;
            end
            if (r < NUM_MIN)
            begin
                r = NUM_MIN;
                sat = 1;
            end
            res.source = raw;
            res.numerator = r[31:0];
            res.denominator = hd[16:0];
            res.exact = found;
            res.saturated = sat;
            return res;
        endfunction

        function void note_value(logic [31:0] raw, int unsigned lim);
            expected_q.push_back(predict_approx(raw, lim));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        task report(string what, logic [31:0] src, longint unsigned got, longint unsigned want);
            $display("mismatch %s for value %h: got %0h, want %0h", what, src, got, want);
            errors++;
        endtask

        task check_result(logic [31:0] num, logic [16:0] den, logic ex, logic sat);
            approx_t want;
            if (expected_q.size() == 0)
            begin
                report("unexpected result", 32'h0, num, 0);
                return;
            end
            want = expected_q.pop_front();
            if (num !== want.numerator)
                report("numerator", want.source, num, want.numerator);
            if (den !== want.denominator)
                report("denominator", want.source, den, want.denominator);
            if (ex !== want.exact)
                report("exact", want.source, ex, want.exact);
            if (sat !== want.saturated)
                report("saturated", want.source, sat, want.saturated);
        endtask

        task close();
            while (expected_q.size() != 0)
                report("missing result", expected_q.pop_front().source, 0, 1);
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic signed [31:0]            value;
    logic                          done;
    logic signed [31:0]            numerator;
    logic [16:0]                   denominator;
    logic                          exact;
    logic                          saturated;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [farey_pkg::LIMIT_W-1:0] cfg_data;

    approx_scoreboard sb;
    int unsigned cur_limit;
    int stall_count;

    farey_mediant_rational_approx #(
        .FRAC_BITS(FRAC)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .done(done),
        .numerator(numerator),
        .denominator(denominator),
        .exact(exact),
        .saturated(saturated),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_result(numerator, denominator, exact, saturated);
    end

    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1
            || (cfg_valid === 1'b1 && cfg_ready === 1'b1))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("farey_mediant_rational_approx regression: fail");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task send_value(logic [31:0] v);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_value(v, cur_limit);
        @(negedge clk);
    endtask

    task drain();
        start <= 1'b0;
        while (sb.pending() != 0 || busy !== 1'b0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        @(negedge clk);
    endtask

    task write_limit(logic [farey_pkg::LIMIT_W-1:0] lim);
        cfg_valid <= 1'b1;
        cfg_data <= lim;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cur_limit = lim;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function logic [31:0] rand_value();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(9))
            0, 1: v[15:0] = 16'h0000;
            2: v[15:0] = 16'($urandom_range(15, 1));
            3: v[15:0] = 16'hFFFF - 16'($urandom_range(15));
            default: ;
        endcase
        return v;
    endfunction

    initial
    begin
        logic [31:0] dir_reset[$];
        logic [31:0] dir_zero[$];
        logic [31:0] dir_one[$];
        logic [31:0] dir_max[$];
        int unsigned phase_limit[PHASES];
        int idle_pct[PHASES];
        dir_reset = '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'h00010000,
                      32'hFFFF0000, 32'h00008000, 32'h00000001, 32'h0000FFFF, 32'h00005555,
                      32'h12345678, 32'hFFFF8000, 32'h80000001, 32'h7FFF0000};
        dir_zero = '{32'h00030000, 32'h7FFFFFFF, 32'h80000000};
        dir_one = '{32'h00008000, 32'h00004000, 32'hFFFFC000};
        dir_max = '{32'h00000001, 32'h80000001};
        phase_limit = '{10000, 1, 65535, $urandom_range(400, 2), 0};
        idle_pct = '{0, 53, 18, 53, 0};
        sb = new();
        stall_count = 0;
        cur_limit = farey_pkg::LIMIT_RESET;
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset limit, then zero, one and the largest limit
        foreach (dir_reset[i])
            send_value(dir_reset[i]);
        drain();
        write_limit(16'd0);
        foreach (dir_zero[i])
            send_value(dir_zero[i]);
        drain();
        write_limit(16'd1);
        foreach (dir_one[i])
            send_value(dir_one[i]);
        drain();
        write_limit(16'hFFFF);
        foreach (dir_max[i])
            send_value(dir_max[i]);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            write_limit(phase_limit[p][15:0]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (idle_pct[p] > 0 && $urandom_range(99) < idle_pct[p])
                begin
                    start <= 1'b0;
                    do
                        @(negedge clk);
                    while ($urandom_range(99) < idle_pct[p]);
                end
                send_value(rand_value());
                // halfway through the second phase, the sender holds off until the block has caught up
                if (p == 1 && n == PHASE_ITEMS / 2)
                    drain();
            end
            drain();
        end

        repeat (10) @(posedge clk);
        sb.close();
        if (sb.errors == 0)
            $display("farey_mediant_rational_approx regression: pass");
        else
            $display("farey_mediant_rational_approx regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
